### rtl/core/grid_line_scanner_top_macros.svh
// assertion helpers for the grid line scanner
// both macros sample on the rising edge of clock and are off during reset
`ifndef GRID_LINE_SCANNER_TOP_MACROS_SVH
`define GRID_LINE_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define GLS_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GLS_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types and codes of the grid line scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gls_pkg;

   // width of the row and column count registers
   localparam int CNT_W   = 5;
   localparam int COORD_W = 4;
   localparam int VALUE_W = 2;
   localparam int KIND_W  = 3;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ROW_COUNT    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_COLUMN_COUNT = 3'd4;

   localparam logic [CNT_W-1:0] ROW_COUNT_RESET    = 5'd3;
   localparam logic [CNT_W-1:0] COLUMN_COUNT_RESET = 5'd3;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_NEXT    = 2'd2
   } cmd_type;

   localparam logic [KIND_W-1:0] KIND_ROW       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_COLUMN    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DIAG_LEFT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DIAG_TOP  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ANTI_RIGHT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ANTI_TOP  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_END       = 3'd6;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEEK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               done;
      logic               last;
      logic [COORD_W-1:0] pos;
      logic [COORD_W-1:0] line;
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } meta_type;

endpackage

### rtl/core/gls_ram.sv
// ----------------------------------------------------------------------------
// gls_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gls_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read data only changes on a read, so it doubles as a holding stage
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

### rtl/core/grid_line_scanner_top.sv
// write and restart words are handled in idle itself; a next-line word steps past each
// line kind it skips, sets up the line, then issues one grid memory read per cycle
// while the p stage is free; each word then passes the p and out stages to rsp. the
// single memory read port sets this rate.
// after reset the grid is zeroed one cell per cycle, all MAX_ROWS * MAX_COLUMNS
// cells (256 by default), with req_tready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// grid_line_scanner_top
// Cell grid in a memory, streamed out line by line: rows, columns, diagonals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_line_scanner_top #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLUMNS = 16,
   parameter int CELL_BITS   = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   // command[1:0], write_row[5:2], write_column[9:6], write_value[11:10]
   input  logic [gls_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cell_row[3:0], cell_column[7:4], cell_value[9:8], line_number[13:10],
   // position[17:14]
   output logic [gls_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // line_kind[2:0], done_res[3]
   output logic [gls_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gls_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gls_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gls_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import gls_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      min_cnt = (a < b) ? a : b;
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [CNT_W-1:0]   line_ff, line_in;
   logic [CNT_W-1:0]   cur_r_ff, cur_r_in;
   logic [CNT_W-1:0]   cur_c_ff, cur_c_in;
   logic               row_inc_ff, row_inc_in;
   logic               col_inc_ff, col_inc_in;
   logic               col_dec_ff, col_dec_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   row_count_ff, column_count_ff;

   logic               p_valid_ff, p_valid_in;
   meta_type           p_meta_ff, p_meta_in;
   logic               p_load;
   logic               out_valid_ff, out_valid_in;
   meta_type           out_meta_ff;
   logic [VALUE_W-1:0] out_value_ff;

   logic               out_free, p_move, p_free;
   logic [CNT_W-1:0]   r_eff, c_eff, lines_cur, line_next;
   logic               last_elem;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

   cmd_type            req_cmd;
   logic [COORD_W-1:0] req_row, req_col;
   logic [VALUE_W-1:0] req_value;
   logic               csr_write;

   assign req_cmd   = cmd_type'(req_tdata[1:0]);
   assign req_row   = req_tdata[5:2];
   assign req_col   = req_tdata[9:6];
   assign req_value = req_tdata[11:10];

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_COUNT_RESET;
         column_count_ff <= COLUMN_COUNT_RESET;
      end else if (csr_write) begin
         if (csr_paddr == ADDR_ROW_COUNT) begin
            row_count_ff <= csr_pwdata[CNT_W-1:0];
         end
         if (csr_paddr == ADDR_COLUMN_COUNT) begin
            column_count_ff <= csr_pwdata[CNT_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_ROW_COUNT:    csr_prdata = CSR_DATA_W'(row_count_ff);
         ADDR_COLUMN_COUNT: csr_prdata = CSR_DATA_W'(column_count_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // counts clamped to the grid size
   assign r_eff = (int'(row_count_ff) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count_ff;
   assign c_eff = (int'(column_count_ff) > MAX_COLUMNS) ?
                  CNT_W'(MAX_COLUMNS) : column_count_ff;
   assign lines_cur = kind_ff[0] ? c_eff : r_eff;
   assign line_next = line_ff + 1'b1;
   assign last_elem = ((pos_ff + 1'b1) == len_ff);

   // ---------------- output pipeline ----------------
   // p stage: memory read data plus its tag; out stage: the word on rsp
   assign out_free = !out_valid_ff || rsp_tready;
   assign p_move   = p_valid_ff && out_free;
   assign p_free   = !p_valid_ff || p_move;

   assign p_valid_in   = p_load || (p_valid_ff && !p_move);
   assign out_valid_in = p_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_load) begin
         p_meta_ff <= p_meta_in;
      end
      if (p_move) begin
         out_meta_ff  <= p_meta_ff;
         out_value_ff <= p_meta_ff.done ? '0 : VALUE_W'(ram_rdata);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_meta_ff.last;
   assign rsp_tuser  = {out_meta_ff.done, out_meta_ff.kind};
   assign rsp_tdata  = {6'b0, out_meta_ff.pos, out_meta_ff.line, out_value_ff,
                        out_meta_ff.col, out_meta_ff.row};

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         kind_ff     <= KIND_ROW;
         line_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         kind_ff     <= kind_in;
         line_ff     <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_r_ff   <= cur_r_in;
      cur_c_ff   <= cur_c_in;
      row_inc_ff <= row_inc_in;
      col_inc_ff <= col_inc_in;
      col_dec_ff <= col_dec_in;
      len_ff     <= len_in;
      pos_ff     <= pos_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      kind_in     = kind_ff;
      line_in     = line_ff;
      cur_r_in    = cur_r_ff;
      cur_c_in    = cur_c_ff;
      row_inc_in  = row_inc_ff;
      col_inc_in  = col_inc_ff;
      col_dec_in  = col_dec_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      req_tready  = 1'b0;
      p_load      = 1'b0;
      p_meta_in   = '0;
      ram_we      = 1'b0;
      ram_waddr   = AW'(int'(req_row) * MAX_COLUMNS + int'(req_col));
      ram_wdata   = CELL_BITS'(req_value);
      ram_re      = 1'b0;
      ram_raddr   = AW'(int'(cur_r_ff) * MAX_COLUMNS + int'(cur_c_ff));

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_cmd)
                  CMD_WRITE: begin
                     ram_we = (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLUMNS);
                  end
                  CMD_RESTART: begin
                     kind_in = KIND_ROW;
                     line_in = '0;
                  end
                  CMD_NEXT: begin
                     state_in = ST_SEEK;
                  end
                  default: ;
               endcase
            end
         end

         ST_SEEK: begin
            if (r_eff == '0 || c_eff == '0 || kind_ff >= KIND_END) begin
               if (p_free) begin
                  p_load         = 1'b1;
                  p_meta_in.done = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (line_ff >= lines_cur) begin
               // counts shrank under the scan: move on to the next kind
               kind_in = kind_ff + 1'b1;
               line_in = '0;
            end else begin
               pos_in     = '0;
               row_inc_in = 1'b1;
               col_inc_in = 1'b0;
               col_dec_in = 1'b0;
               state_in   = ST_EMIT;
               case (kind_ff)
                  KIND_ROW: begin
                     cur_r_in   = line_ff;
                     cur_c_in   = '0;
                     row_inc_in = 1'b0;
                     col_inc_in = 1'b1;
                     len_in     = c_eff;
                  end
                  KIND_COLUMN: begin
                     cur_r_in = '0;
                     cur_c_in = line_ff;
                     len_in   = r_eff;
                  end
                  KIND_DIAG_LEFT: begin
                     cur_r_in   = line_ff;
                     cur_c_in   = '0;
                     col_inc_in = 1'b1;
                     len_in     = min_cnt(r_eff - line_ff, c_eff);
                  end
                  KIND_DIAG_TOP: begin
                     cur_r_in   = '0;
                     cur_c_in   = line_ff;
                     col_inc_in = 1'b1;
                     len_in     = min_cnt(r_eff, c_eff - line_ff);
                  end
                  KIND_ANTI_RIGHT: begin
                     cur_r_in   = line_ff;
                     cur_c_in   = c_eff - 1'b1;
                     col_dec_in = 1'b1;
                     len_in     = min_cnt(r_eff - line_ff, c_eff);
                  end
                  default: begin
                     cur_r_in   = '0;
                     cur_c_in   = c_eff - 1'b1 - line_ff;
                     col_dec_in = 1'b1;
                     len_in     = min_cnt(r_eff, c_eff - line_ff);
                  end
               endcase
            end
         end

         ST_EMIT: begin
            if (p_free) begin
               ram_re         = 1'b1;
               p_load         = 1'b1;
               p_meta_in.row  = cur_r_ff[COORD_W-1:0];
               p_meta_in.col  = cur_c_ff[COORD_W-1:0];
               p_meta_in.kind = kind_ff;
               p_meta_in.line = line_ff[COORD_W-1:0];
               p_meta_in.pos  = pos_ff[COORD_W-1:0];
               p_meta_in.last = last_elem;
               cur_r_in = cur_r_ff + CNT_W'(row_inc_ff);
               cur_c_in = col_dec_ff ? cur_c_ff - 1'b1 : cur_c_ff + CNT_W'(col_inc_ff);
               pos_in   = pos_ff + 1'b1;
               if (last_elem) begin
                  state_in = ST_IDLE;
                  if (line_next >= lines_cur) begin
                     kind_in = kind_ff + 1'b1;
                     line_in = '0;
                  end else begin
                     line_in = line_next;
                  end
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   gls_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_grid_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

### rtl/core/gls_checker.sv
// ----------------------------------------------------------------------------
// gls_checker
// Port-level checks on the result stream of the grid line scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "grid_line_scanner_top_macros.svh"

module gls_checker (
   input logic                           clock,
   input logic                           reset,
   input logic [gls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [gls_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);

   import gls_pkg::*;

   logic               done;
   logic [KIND_W-1:0]  kind;
   logic [COORD_W-1:0] row, col, line, pos;

   assign done = rsp_tuser[3];
   assign kind = rsp_tuser[2:0];
   assign row  = rsp_tdata[3:0];
   assign col  = rsp_tdata[7:4];
   assign line = rsp_tdata[13:10];
   assign pos  = rsp_tdata[17:14];

   // a stalled word keeps its contents
   `GLS_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp word changed while stalled")

   `GLS_ASSERT_IMP(a_done_clean, rsp_tvalid && done, rsp_tdata == '0 && kind == '0 && !rsp_tlast, "done word carries nonzero fields")

   `GLS_ASSERT_IMP(a_kind_range, rsp_tvalid && !done, kind != KIND_END && kind != 3'd7, "line word with out-of-range kind")

   // rows walk the columns, columns walk the rows
   `GLS_ASSERT_IMP(a_row_geom, rsp_tvalid && !done && kind == KIND_ROW, col == pos && row == line, "row word coordinates inconsistent")

   `GLS_ASSERT_IMP(a_col_geom, rsp_tvalid && !done && kind == KIND_COLUMN, row == pos && col == line, "column word coordinates inconsistent")

endmodule

bind grid_line_scanner_top gls_checker u_gls_checker (.*);
